@@ rtl/tga_rle_pkg.sv @@
`timescale 1ns / 1ps
package tga_rle_pkg;

  // Field widths of the pixel stream and the result channel
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PixelW  = 32;
  localparam int unsigned RepeatW = 8;
  localparam int unsigned TotalW  = 30;
  localparam int unsigned SrcW    = 3;

  // Queue depth between front and back
  localparam int unsigned QueueDepthDef = 2;

  // Register indexes on the APB port
  localparam logic [1:0] RegRunLength  = 2'd0;
  localparam logic [1:0] RegSrcBytes   = 2'd1;
  localparam logic [1:0] RegTrueColor  = 2'd2;
  localparam logic [1:0] RegPixelTotal = 2'd3;

  // Register reset values
  localparam logic              RunLengthRst  = 1'b1;
  localparam logic [SrcW-1:0]   SrcBytesRst   = 3'd4;
  localparam logic              TrueColorRst  = 1'b1;
  localparam logic [TotalW-1:0] PixelTotalRst = 30'd1;

  // Packet header: run flag position
  localparam int unsigned RunFlagBit = 7;

  typedef struct packed {
    logic              run_length_mode;
    logic [SrcW-1:0]   source_bytes;
    logic              true_color;
    logic [TotalW-1:0] pixel_total;
  } cfg_t;

  // One decoded pixel waiting to be shaped and delivered
  typedef struct packed {
    logic [PixelW-1:0]  raw;
    logic               four_bytes;
    logic [RepeatW-1:0] repeat_count;
    logic               last_pixel;
    logic               overrun;
  } q_entry_t;

endpackage

@@ rtl/tga_rle_if.sv @@
`timescale 1ns / 1ps
// Stream byte channel
interface tga_rle_byte_if;
  import tga_rle_pkg::*;
  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

// Decoded pixel channel
interface tga_rle_pix_if;
  import tga_rle_pkg::*;
  logic               valid;
  logic               ready;
  logic [PixelW-1:0]  pixel_value;
  logic [RepeatW-1:0] repeat_count;
  logic               last_pixel;
  logic               overrun;

  modport source (output valid, output pixel_value, output repeat_count,
                  output last_pixel, output overrun, input ready);
  modport sink (input valid, input pixel_value, input repeat_count,
                input last_pixel, input overrun, output ready);
endinterface

@@ rtl/tga_rle_pixel_decoder.sv @@
`timescale 1ns / 1ps
// Channel    Dir  Handshake      Payload
// in_chan    in   valid/ready    stream_byte[7:0]
// out_chan   out  valid/ready    pixel_value[31:0] repeat_count[7:0] last_pixel overrun
// apb        in   psel/penable   paddr[3:0] pwdata[31:0] prdata[31:0], pready tied high
//
// One stream byte is taken per cycle while the queue is not full; a completed pixel
// is decoded and pushed in the cycle its last byte is accepted, then moves from the
// queue into the output register once that register is free or being taken (queue
// pop). rst_ni clears all stream state and loads the defaults. in_chan.ready drops
// only while the queue is full, which happens once QueueDepth pixels wait behind a
// stalled output register.
module tga_rle_pixel_decoder #(
  parameter int unsigned QueueDepth = tga_rle_pkg::QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tga_rle_byte_if.sink  in_chan,
  tga_rle_pix_if.source out_chan,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import tga_rle_pkg::*;

  cfg_t       cfg_q;
  logic       cfg_we;
  logic [1:0] reg_idx;
  logic       byte_fire;
  logic       push;
  q_entry_t   push_entry;
  q_entry_t   head_entry;
  logic       q_full, q_empty, pop;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.run_length_mode <= RunLengthRst;
      cfg_q.source_bytes    <= SrcBytesRst;
      cfg_q.true_color      <= TrueColorRst;
      cfg_q.pixel_total     <= PixelTotalRst;
    end else if (cfg_we) begin
      case (reg_idx)
        RegRunLength:  cfg_q.run_length_mode <= pwdata[0];
        RegSrcBytes:   cfg_q.source_bytes    <= pwdata[SrcW-1:0];
        RegTrueColor:  cfg_q.true_color      <= pwdata[0];
        RegPixelTotal: cfg_q.pixel_total     <= pwdata[TotalW-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      RegRunLength:  prdata = {31'b0, cfg_q.run_length_mode};
      RegSrcBytes:   prdata = {{(32-SrcW){1'b0}}, cfg_q.source_bytes};
      RegTrueColor:  prdata = {31'b0, cfg_q.true_color};
      RegPixelTotal: prdata = {{(32-TotalW){1'b0}}, cfg_q.pixel_total};
      default:       prdata = '0;
    endcase
  end

  assign in_chan.ready = !q_full;
  assign byte_fire     = in_chan.valid && !q_full;

  tga_rle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .byte_fire_i (byte_fire),
    .byte_i      (in_chan.stream_byte),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  tga_rle_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .entry_o (head_entry)
  );

  tga_rle_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .true_color_i (cfg_q.true_color),
    .empty_i      (q_empty),
    .entry_i      (head_entry),
    .pop_o        (pop),
    .out_chan     (out_chan)
  );

endmodule

@@ rtl/tga_rle_front.sv @@
`timescale 1ns / 1ps
module tga_rle_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tga_rle_pkg::cfg_t                cfg_i,
  input  logic                             byte_fire_i,
  input  logic [tga_rle_pkg::ByteW-1:0]    byte_i,
  output logic                             push_o,
  output tga_rle_pkg::q_entry_t            entry_o
);
  import tga_rle_pkg::*;

  logic                expect_q, expect_d;
  logic                run_q, run_d;
  logic [RepeatW-1:0]  left_q, left_d;
  logic [1:0]          bip_q, bip_d;
  logic [PixelW-1:0]   asm_q, asm_d;
  logic [TotalW-1:0]   emitted_q, emitted_d;

  logic [SrcW-1:0]     nbytes;
  logic [TotalW-1:0]   total;
  logic [TotalW-1:0]   remaining;
  logic [RepeatW-1:0]  want;
  logic                run_over;
  logic [TotalW-1:0]   run_rep;
  logic                run_last;
  logic                lit_last;
  logic                rle;
  logic                more_bytes;
  logic [PixelW-1:0]   asm_new;
  logic [RepeatW-1:0]  left_dec;

  // Effective configuration
  assign nbytes = (cfg_i.source_bytes == '0) ? SrcW'(1) :
                  (cfg_i.source_bytes > SrcW'(4)) ? SrcW'(4) : cfg_i.source_bytes;
  assign total  = (cfg_i.pixel_total == '0) ? TotalW'(1) : cfg_i.pixel_total;
  assign rle    = cfg_i.run_length_mode;

  // Byte assembly
  assign more_bytes = ({1'b0, bip_q} + SrcW'(1)) < nbytes;
  assign asm_new    = asm_q | ({{(PixelW-ByteW){1'b0}}, byte_i} << {bip_q, 3'b000});

  // Pixels still allowed in this image
  assign remaining = (emitted_q < total) ? (total - emitted_q) : TotalW'(1);

  // Run packet clipping
  assign want     = (left_q == '0) ? RepeatW'(1) : left_q;
  assign run_over = {{(TotalW-RepeatW){1'b0}}, want} > remaining;
  assign run_rep  = run_over ? remaining : {{(TotalW-RepeatW){1'b0}}, want};
  assign run_last = (run_rep == remaining);

  // Literal pixel bookkeeping
  assign lit_last = (remaining <= TotalW'(1));
  assign left_dec = (left_q != '0) ? (left_q - RepeatW'(1)) : left_q;

  // Decode one stream byte
  always_comb begin
    expect_d  = expect_q;
    run_d     = run_q;
    left_d    = left_q;
    bip_d     = bip_q;
    asm_d     = asm_q;
    emitted_d = emitted_q;
    push_o    = 1'b0;
    entry_o   = '0;
    entry_o.raw        = asm_new;
    entry_o.four_bytes = (nbytes == SrcW'(4));
    if (byte_fire_i) begin
      if (rle && expect_q) begin
        run_d    = byte_i[RunFlagBit];
        left_d   = {1'b0, byte_i[RunFlagBit-1:0]} + RepeatW'(1);
        expect_d = 1'b0;
        bip_d    = '0;
        asm_d    = '0;
      end else if (more_bytes) begin
        asm_d = asm_new;
        bip_d = bip_q + 2'd1;
      end else begin
        push_o = 1'b1;
        bip_d  = '0;
        asm_d  = '0;
        if (rle && run_q) begin
          entry_o.repeat_count = run_rep[RepeatW-1:0];
          entry_o.overrun      = run_over;
          entry_o.last_pixel   = run_last;
          left_d   = '0;
          expect_d = 1'b1;
        end else begin
          entry_o.repeat_count = RepeatW'(1);
          entry_o.last_pixel   = lit_last;
          if (rle) begin
            left_d = left_dec;
            if (left_dec == '0) begin
              expect_d = 1'b1;
            end else if (lit_last) begin
              entry_o.overrun = 1'b1;
            end
          end
        end
        // Rearm for the next image, drop the rest of the packet
        if (entry_o.last_pixel) begin
          emitted_d = '0;
          expect_d  = 1'b1;
          run_d     = 1'b0;
          left_d    = '0;
        end else begin
          emitted_d = emitted_q + {{(TotalW-RepeatW){1'b0}}, entry_o.repeat_count};
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_q  <= 1'b1;
      run_q     <= 1'b0;
      left_q    <= '0;
      bip_q     <= '0;
      asm_q     <= '0;
      emitted_q <= '0;
    end else begin
      expect_q  <= expect_d;
      run_q     <= run_d;
      left_q    <= left_d;
      bip_q     <= bip_d;
      asm_q     <= asm_d;
      emitted_q <= emitted_d;
    end
  end

endmodule

@@ rtl/tga_rle_queue.sv @@
`timescale 1ns / 1ps
module tga_rle_queue #(
  parameter int unsigned Depth = tga_rle_pkg::QueueDepthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  tga_rle_pkg::q_entry_t  entry_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   empty_o,
  output tga_rle_pkg::q_entry_t  entry_o
);
  import tga_rle_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  q_entry_t          mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d;
  logic [PtrW-1:0]   rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Hold entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

@@ rtl/tga_rle_back.sv @@
`timescale 1ns / 1ps
module tga_rle_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   true_color_i,
  input  logic                   empty_i,
  input  tga_rle_pkg::q_entry_t  entry_i,
  output logic                   pop_o,
  tga_rle_pix_if.source          out_chan
);
  import tga_rle_pkg::*;

  logic               valid_q, valid_d;
  logic [PixelW-1:0]  pixel_q;
  logic [RepeatW-1:0] rep_q;
  logic               last_q;
  logic               over_q;
  logic [PixelW-1:0]  shaped;
  logic [ByteW-1:0]   alpha;

  // In true-color mode swap B and R and fill alpha for short pixels; else pass raw
  assign alpha  = entry_i.four_bytes ? entry_i.raw[31:24] : 8'hFF;
  assign shaped = true_color_i ?
                  {alpha, entry_i.raw[7:0], entry_i.raw[15:8], entry_i.raw[23:16]} :
                  entry_i.raw;

  // Load the output register when it is free or being taken
  assign pop_o   = !empty_i && (!valid_q || out_chan.ready);
  assign valid_d = pop_o ? 1'b1 : (out_chan.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pixel_q <= shaped;
      rep_q   <= entry_i.repeat_count;
      last_q  <= entry_i.last_pixel;
      over_q  <= entry_i.overrun;
    end
  end

  assign out_chan.valid        = valid_q;
  assign out_chan.pixel_value  = pixel_q;
  assign out_chan.repeat_count = rep_q;
  assign out_chan.last_pixel   = last_q;
  assign out_chan.overrun      = over_q;

endmodule

@@ rtl/tga_rle_checker.sv @@
`timescale 1ns / 1ps
module tga_rle_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] pixel_value_i,
  input logic [7:0]  repeat_count_i,
  input logic        last_pixel_i,
  input logic        overrun_i
);

  // No result during reset
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  // Stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(pixel_value_i) && $stable(repeat_count_i) &&
      $stable(last_pixel_i) && $stable(overrun_i))
    else $error("stalled result changed");

  // Repeat count stays within one packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (repeat_count_i != 8'd0) && (repeat_count_i <= 8'd128))
    else $error("repeat count out of range");

  // A clipped packet always closes the image
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && overrun_i |-> last_pixel_i)
    else $error("overrun without last pixel");

endmodule

bind tga_rle_pixel_decoder tga_rle_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_chan.valid),
  .out_ready_i    (out_chan.ready),
  .pixel_value_i  (out_chan.pixel_value),
  .repeat_count_i (out_chan.repeat_count),
  .last_pixel_i   (out_chan.last_pixel),
  .overrun_i      (out_chan.overrun)
);
